[design/lsm_pkg.sv]
// ----------------------------------------------------------------------------
// lsm_pkg
// Shared types for the list scheduling block: the load update command that
// the controller sends to every machine cell.
// ----------------------------------------------------------------------------
package lsm_pkg;

  typedef struct packed {
    logic write;
    logic clear;
  } lsm_upd_t;

endpackage

[design/lsm_cell.sv]
// ----------------------------------------------------------------------------
// lsm_cell
// One machine of the scheduler. Holds the machine load, folds it into the
// minimum-scan beat that passes through, and takes load updates and clears.
// ----------------------------------------------------------------------------
module lsm_cell
  import lsm_pkg::*;
#(
  parameter int IDX       = 0,
  parameter int IDX_BITS  = 4,
  parameter int NUM_BITS  = 5,
  parameter int LOAD_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [NUM_BITS-1:0]  num_use,
  input  logic                 scan_in_valid,
  input  logic [LOAD_BITS-1:0] scan_in_load,
  input  logic [IDX_BITS-1:0]  scan_in_idx,
  output logic                 scan_out_valid,
  output logic [LOAD_BITS-1:0] scan_out_load,
  output logic [IDX_BITS-1:0]  scan_out_idx,
  input  lsm_upd_t             upd,
  input  logic [IDX_BITS-1:0]  upd_idx,
  input  logic [LOAD_BITS-1:0] upd_load
);

  localparam logic [IDX_BITS-1:0] MY_IDX = IDX_BITS'(IDX);

  logic [LOAD_BITS-1:0] load;
  logic                 in_use;
  logic                 take;

  assign in_use = NUM_BITS'(IDX) < num_use;
  assign take   = (IDX == 0) || (in_use && (load < scan_in_load));

  always_ff @(posedge clk) begin
    if (rst) begin
      load <= '0;
    end else if (upd.clear) begin
      load <= '0;
    end else if (upd.write && (upd_idx == MY_IDX)) begin
      load <= upd_load;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_out_valid <= 1'b0;
    end else begin
      scan_out_valid <= scan_in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      scan_out_load <= load;
      scan_out_idx  <= MY_IDX;
    end else begin
      scan_out_load <= scan_in_load;
      scan_out_idx  <= scan_in_idx;
    end
  end

endmodule

[design/list_scheduling_makespan.sv]
// The minimum scan beat walks the chain of machine cells one cell per cycle;
// the block takes one task at a time and takes no new task while a scan
// or load update is still under way.
// A new task is taken while the previous result still waits.
// Reset (synchronous, active high) clears all loads and the running makespan
// and sets the configured machine count to 16; no clearing pass is needed.
// ----------------------------------------------------------------------------
// list_scheduling_makespan
// Greedy list scheduling onto identical machines: each task goes to the
// least-loaded machine (lowest index on ties), loads saturate, and the
// running makespan is reported. The last task of an instance clears all.
// ----------------------------------------------------------------------------
module list_scheduling_makespan
  import lsm_pkg::*;
#(
  parameter int MAX_MACHINES = 16,
  parameter int LOAD_BITS    = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [4:0]                   num_machines,
  input  logic                         task_valid,
  output logic                         task_ready,
  input  logic [15:0]                  task_duration,
  input  logic                         last_task,
  output logic                         result_valid,
  input  logic                         result_ready,
  output logic [$clog2(MAX_MACHINES)-1:0] machine_index,
  output logic [LOAD_BITS-1:0]         machine_load,
  output logic [LOAD_BITS-1:0]         makespan,
  output logic                         instance_done
);

  localparam int IW = $clog2(MAX_MACHINES);
  localparam int NW = $clog2(MAX_MACHINES + 1);
  localparam logic [LOAD_BITS-1:0] LOAD_MAX = '1;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DONE} state_t;

  state_t               state;
  logic [4:0]           num_cfg;
  logic [NW-1:0]        num_use;
  logic [15:0]          dur;
  logic                 last;
  logic                 start;
  logic [LOAD_BITS-1:0] min_load;
  logic [IW-1:0]        min_idx;
  logic [LOAD_BITS-1:0] run_span;
  logic [LOAD_BITS:0]   sum;
  logic [LOAD_BITS-1:0] new_load;
  logic [LOAD_BITS-1:0] span_next;
  logic                 fire;
  lsm_upd_t             upd;

  logic [MAX_MACHINES:0]                scan_valid;
  logic [MAX_MACHINES:0][LOAD_BITS-1:0] scan_load;
  logic [MAX_MACHINES:0][IW-1:0]        scan_idx;

  assign cfg_ready  = 1'b1;
  assign task_ready = (state == S_IDLE);

  always_comb begin
    if (num_cfg == 5'd0) begin
      num_use = NW'(1);
    end else if (32'(num_cfg) > MAX_MACHINES) begin
      num_use = NW'(MAX_MACHINES);
    end else begin
      num_use = NW'(num_cfg);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      num_cfg <= 5'd16;
    end else if (cfg_valid && cfg_ready) begin
      num_cfg <= num_machines;
    end
  end

  assign scan_valid[0] = start;
  assign scan_load[0]  = '0;
  assign scan_idx[0]   = '0;

  for (genvar i = 0; i < MAX_MACHINES; i++) begin : g_cell
    lsm_cell #(
      .IDX       (i),
      .IDX_BITS  (IW),
      .NUM_BITS  (NW),
      .LOAD_BITS (LOAD_BITS)
    ) u_cell (
      .clk            (clk),
      .rst            (rst),
      .num_use        (num_use),
      .scan_in_valid  (scan_valid[i]),
      .scan_in_load   (scan_load[i]),
      .scan_in_idx    (scan_idx[i]),
      .scan_out_valid (scan_valid[i+1]),
      .scan_out_load  (scan_load[i+1]),
      .scan_out_idx   (scan_idx[i+1]),
      .upd            (upd),
      .upd_idx        (min_idx),
      .upd_load       (new_load)
    );
  end

  assign sum       = {1'b0, min_load} + (LOAD_BITS+1)'(dur);
  assign new_load  = sum[LOAD_BITS] ? LOAD_MAX : sum[LOAD_BITS-1:0];
  assign span_next = (new_load > run_span) ? new_load : run_span;
  assign fire      = (state == S_DONE) && (!result_valid || result_ready);
  assign upd.write = fire;
  assign upd.clear = fire && last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      start        <= 1'b0;
      run_span     <= '0;
      result_valid <= 1'b0;
    end else begin
      start        <= (state == S_IDLE) && task_valid;
      result_valid <= fire || (result_valid && !result_ready);
      unique case (state)
        S_IDLE: begin
          if (task_valid) begin
            dur   <= task_duration;
            last  <= last_task;
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (scan_valid[MAX_MACHINES]) begin
            min_load <= scan_load[MAX_MACHINES];
            min_idx  <= scan_idx[MAX_MACHINES];
            state    <= S_DONE;
          end
        end
        S_DONE: begin
          if (fire) begin
            machine_index <= min_idx;
            machine_load  <= new_load;
            makespan      <= span_next;
            instance_done <= last;
            run_span      <= last ? '0 : span_next;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_one_scan: assert property (@(posedge clk) disable iff (rst)
    $onehot0(scan_valid))
    else $error("more than one scan beat in the cell chain");

  a_idle_no_scan: assert property (@(posedge clk) disable iff (rst)
    task_ready |-> (scan_valid == '0))
    else $error("scan beat in flight while taking a task");

  a_scan_end_state: assert property (@(posedge clk) disable iff (rst)
    scan_valid[MAX_MACHINES] |-> (state == S_SCAN))
    else $error("scan finished outside the scan state");

  a_update_result: assert property (@(posedge clk) disable iff (rst)
    upd.write |=> result_valid)
    else $error("load update without a result");

  a_span_bound: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (makespan >= machine_load))
    else $error("makespan below chosen machine load");

endmodule
